>>> hdl/sitda_pkg.sv
// ----------------------------------------------------------------------------
// sitda_pkg
// Shared types and constants for the signed integer to decimal text block.
// ----------------------------------------------------------------------------
package sitda_pkg;

   localparam int VALUE_WIDTH_DEF = 64;

   localparam logic [7:0] CHAR_ZERO  = 8'd48;
   localparam logic [7:0] CHAR_NINE  = 8'd57;
   localparam logic [7:0] CHAR_MINUS = 8'd45;

   // per-cycle command to every digit cell
   typedef struct packed {
      logic clear;
      logic dabble;
      logic shift;
   } cell_ctrl_type;

endpackage
// ----------------------------------------------------------------------------

>>> hdl/sitda_cell.sv
// ----------------------------------------------------------------------------
// sitda_cell
// One BCD digit of the shift-and-add-3 chain; also shifts digits out.
// ----------------------------------------------------------------------------
module sitda_cell (
   input  logic                    clock,
   input  sitda_pkg::cell_ctrl_type ctrl,
   input  logic                    carry_from_low,
   input  logic [3:0]              lower_digit,
   output logic                    carry_to_high,
   output logic [3:0]              digit
);
   import sitda_pkg::*;

   logic [3:0] digit_ff;
   logic [3:0] digit_in;
   logic [3:0] adj;

   assign adj           = (digit_ff >= 4'd5) ? (digit_ff + 4'd3) : digit_ff;
   assign carry_to_high = adj[3];
   assign digit         = digit_ff;

   always_comb begin
      digit_in = digit_ff;
      if (ctrl.clear) begin
         digit_in = 4'd0;
      end else if (ctrl.dabble) begin
         digit_in = {adj[2:0], carry_from_low};
      end else if (ctrl.shift) begin
         digit_in = lower_digit;
      end
   end

   always_ff @(posedge clock) begin
      digit_ff <= digit_in;
   end

endmodule
// ----------------------------------------------------------------------------

>>> hdl/signed_int_to_decimal_ascii_top.sv
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_top
// Converts a signed integer to decimal ASCII text, most significant first.
//
//   channel   ports                               handshake
//   request   req_value                           start && !busy
//   response  rsp_text_char, rsp_last_char        rsp_strobe, one cycle
//
// A request holds busy while each magnitude bit passes through the digit-cell
// chain, then while a minus sign is sent if the value is negative, and then
// while the chain shifts out each digit position, most significant first.
// Leading zero positions produce no response. Reset clears control only.
// The receiver cannot stall; responses are registered, in the cycle after decision.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_top #(
   parameter int VALUE_WIDTH = sitda_pkg::VALUE_WIDTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [63:0] req_value,
   output logic        rsp_strobe,
   output logic [7:0]  rsp_text_char,
   output logic        rsp_last_char
);
   import sitda_pkg::*;

   localparam int NUM_DIGITS = ((VALUE_WIDTH - 1) * 30103) / 100000 + 1;
   localparam int CW         = $clog2(VALUE_WIDTH);
   localparam int DCW        = $clog2(NUM_DIGITS + 1);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_CONV = 2'd1;
   localparam logic [1:0] S_SIGN = 2'd2;
   localparam logic [1:0] S_EMIT = 2'd3;

   logic [1:0]             state_ff,   state_in;
   logic [VALUE_WIDTH-1:0] mag_ff,     mag_in;
   logic                   neg_ff,     neg_in;
   logic [CW-1:0]          bit_cnt_ff, bit_cnt_in;
   logic [DCW-1:0]         dig_cnt_ff, dig_cnt_in;
   logic                   started_ff, started_in;
   logic                   strobe_ff,  strobe_in;
   logic [7:0]             char_ff,    char_in;
   logic                   last_ff,    last_in;

   logic                   accept;
   logic [VALUE_WIDTH-1:0] raw;
   logic [3:0]             top_digit;
   logic                   emit;
   cell_ctrl_type          ctrl;

   logic [3:0] cell_digit [NUM_DIGITS];
   logic       cell_carry [NUM_DIGITS+1];

   assign busy   = (state_ff != S_IDLE);
   assign accept = start && !busy;
   assign raw    = req_value[VALUE_WIDTH-1:0];

   assign ctrl.clear  = accept;
   assign ctrl.dabble = (state_ff == S_CONV);
   assign ctrl.shift  = (state_ff == S_EMIT);

   assign cell_carry[0] = mag_ff[VALUE_WIDTH-1];

   genvar g;
   generate
      for (g = 0; g < NUM_DIGITS; g++) begin : g_cell
         sitda_cell u_cell (
            .clock          (clock),
            .ctrl           (ctrl),
            .carry_from_low (cell_carry[g]),
            .lower_digit    ((g == 0) ? 4'd0 : cell_digit[(g == 0) ? 0 : g-1]),
            .carry_to_high  (cell_carry[g+1]),
            .digit          (cell_digit[g])
         );
      end
   endgenerate

   assign top_digit = cell_digit[NUM_DIGITS-1];
   assign emit      = started_ff || (top_digit != 4'd0) || (dig_cnt_ff == DCW'(1));

   always_comb begin
      state_in   = state_ff;
      mag_in     = mag_ff;
      neg_in     = neg_ff;
      bit_cnt_in = bit_cnt_ff;
      dig_cnt_in = dig_cnt_ff;
      started_in = started_ff;
      strobe_in  = 1'b0;
      char_in    = char_ff;
      last_in    = last_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               neg_in     = raw[VALUE_WIDTH-1];
               mag_in     = raw[VALUE_WIDTH-1] ? (~raw + VALUE_WIDTH'(1)) : raw;
               bit_cnt_in = '0;
               started_in = 1'b0;
               state_in   = S_CONV;
            end
         end
         S_CONV: begin
            mag_in     = {mag_ff[VALUE_WIDTH-2:0], 1'b0};
            bit_cnt_in = bit_cnt_ff + CW'(1);
            if (bit_cnt_ff == CW'(VALUE_WIDTH - 1)) begin
               dig_cnt_in = DCW'(NUM_DIGITS);
               state_in   = neg_ff ? S_SIGN : S_EMIT;
            end
         end
         S_SIGN: begin
            strobe_in = 1'b1;
            char_in   = CHAR_MINUS;
            last_in   = 1'b0;
            state_in  = S_EMIT;
         end
         S_EMIT: begin
            strobe_in  = emit;
            char_in    = CHAR_ZERO + {4'd0, top_digit};
            last_in    = (dig_cnt_ff == DCW'(1));
            started_in = emit;
            dig_cnt_in = dig_cnt_ff - DCW'(1);
            if (dig_cnt_ff == DCW'(1)) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff     <= mag_in;
      neg_ff     <= neg_in;
      bit_cnt_ff <= bit_cnt_in;
      dig_cnt_ff <= dig_cnt_in;
      started_ff <= started_in;
      char_ff    <= char_in;
      last_ff    <= last_in;
   end

   assign rsp_strobe    = strobe_ff;
   assign rsp_text_char = char_ff;
   assign rsp_last_char = last_ff;

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("busy not raised after request");

   a_char_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_text_char == CHAR_MINUS) ||
                     ((rsp_text_char >= CHAR_ZERO) && (rsp_text_char <= CHAR_NINE)))
      else $error("response character out of range");

   a_sign_first: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SIGN) |=> rsp_strobe && (rsp_text_char == CHAR_MINUS) && !rsp_last_char)
      else $error("sign character not emitted");

   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_last_char) |-> !busy)
      else $error("last character while still converting");

endmodule
// ----------------------------------------------------------------------------

>>> dv/signed_int_to_decimal_ascii_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_top_tb
// Drives signed integers into the decimal text converter and compares every
// character strobed out against a predicted character stream. Directed edge
// values come first, then random values in phases with and without sender idling.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_top_tb;

   localparam int VW         = sitda_pkg::VALUE_WIDTH_DEF;
   localparam int STALL_MAX  = 1000;
   localparam int DRAIN_WAIT = 100;
   localparam int PHASE_REQS = 120;

   class text_scoreboard;
      typedef struct packed {
         logic [7:0] ch;
         logic       last;
      } text_char_type;

      text_char_type pending_chars[$];
      int            failures;
      int            width;

      function new(int w);
         width    = w;
         failures = 0;
      endfunction

      function void note_request(logic [63:0] v);
         logic [63:0]   mask, sign_bit, raw, mag;
         logic          neg;
         logic [7:0]    digits[20];
         int            w, nd;
         text_char_type tc;
         w = width;
         if (w < 1) w = 1;
         if (w > 64) w = 64;
         mask     = (w == 64) ? '1 : ((64'd1 << w) - 64'd1);
         sign_bit = 64'd1 << (w - 1);
         raw      = v & mask;
         neg      = (raw & sign_bit) != 0;
         mag      = neg ? ((~raw + 64'd1) & mask) : raw;
         if (neg && mag == 0) mag = sign_bit;
         nd = 0;
         do begin
            digits[nd] = sitda_pkg::CHAR_ZERO + 8'(mag % 64'd10);
            nd++;
            mag = mag / 64'd10;
         end while (mag != 0 && nd < 19);
         if (neg) begin
            tc.ch   = sitda_pkg::CHAR_MINUS;
            tc.last = 1'b0;
            pending_chars.push_back(tc);
         end
         for (int i = nd - 1; i >= 0; i--) begin
            tc.ch   = digits[i];
            tc.last = (i == 0);
            pending_chars.push_back(tc);
         end
      endfunction

      function void check_response(logic [7:0] ch, logic last);
         text_char_type exp_tc;
         if (pending_chars.size() == 0) begin
            failures++;
            if (failures <= 10)
               $display("unexpected response: char %0d last %0b", ch, last);
            return;
         end
         exp_tc = pending_chars.pop_front();
         if (ch !== exp_tc.ch || last !== exp_tc.last) begin
            failures++;
            if (failures <= 10)
               $display("mismatch: expected char %0d last %0b, got char %0d last %0b",
                        exp_tc.ch, exp_tc.last, ch, last);
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset;
   logic        start;
   logic        busy;
   logic [63:0] req_value;
   logic        rsp_strobe;
   logic [7:0]  rsp_text_char;
   logic        rsp_last_char;

   text_scoreboard sb;
   int             stall_cycles;
   int             phase_pct[4] = '{0, 49, 0, 23};

   signed_int_to_decimal_ascii_top #(
      .VALUE_WIDTH(VW)
   ) dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_value     (req_value),
      .rsp_strobe    (rsp_strobe),
      .rsp_text_char (rsp_text_char),
      .rsp_last_char (rsp_last_char)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) sb.note_request(req_value);
         if (rsp_strobe) sb.check_response(rsp_text_char, rsp_last_char);
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_MAX) begin
            $display("signed_int_to_decimal_ascii_top test failed");
            $finish;
         end
      end
   end

   function automatic logic [63:0] pow10(int k);
      logic [63:0] p;
      p = 64'd1;
      for (int i = 0; i < k; i++) p = p * 64'd10;
      return p;
   endfunction

   function automatic logic [63:0] random_value();
      logic [63:0] mag;
      logic        neg;
      int          k;
      neg = 1'($urandom_range(1));
      k   = $urandom_range(1, 18);
      case ($urandom_range(4))
         0: return {$urandom, $urandom};
         1: mag = 64'($urandom_range(0, 999));
         2: mag = {$urandom, $urandom} % pow10(k);
         3: mag = pow10(k) + 64'($urandom_range(0, 2)) - 64'd1;
         default: begin
            mag = {1'b0, {63{1'b1}}} - 64'($urandom_range(0, 3));
            if (neg) mag = mag + 64'd1;
         end
      endcase
      return neg ? (~mag + 64'd1) : mag;
   endfunction

   // leaves start high after acceptance; the next request decides whether to drop it, drain_responses drops it
   task automatic send_request(input logic [63:0] v, input int idle_pct);
      if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         if ($urandom_range(7) == 0) begin
            repeat ($urandom_range(1, 120)) @(posedge clock);
         end else begin
            do @(posedge clock); while ($urandom_range(99) < idle_pct);
         end
      end
      start     <= 1'b1;
      req_value <= v;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic drain_responses();
      start <= 1'b0;
      @(posedge clock);
      while (sb.pending_chars.size() != 0) @(posedge clock);
   endtask

   initial begin
      logic [63:0] directed[$];
      sb        = new(VW);
      reset     = 1'b1;
      start     = 1'b0;
      req_value = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      directed = '{64'd0, 64'd1, -64'sd1, 64'd9, 64'd10, -64'sd10, 64'd99, 64'd100,
                   64'h7fff_ffff_ffff_ffff, 64'h8000_0000_0000_0000,
                   64'h8000_0000_0000_0001, 64'd999999999999999999,
                   64'd1000000000000000000, -64'sd1000000000000000000,
                   64'd1234567890123456789, -64'sd987654321, 64'hffff_ffff_0000_0000,
                   64'h0000_0000_ffff_ffff, 64'haaaa_aaaa_aaaa_aaaa,
                   64'h5555_5555_5555_5555};
      foreach (directed[i]) send_request(directed[i], 0);
      drain_responses();

      for (int p = 0; p < 4; p++) begin
         for (int n = 0; n < PHASE_REQS; n++) send_request(random_value(), phase_pct[p]);
         drain_responses();
      end

      repeat (DRAIN_WAIT) @(posedge clock);
      if (sb.failures == 0 && sb.pending_chars.size() == 0) begin
         $display("signed_int_to_decimal_ascii_top test passed");
      end else begin
         $display("signed_int_to_decimal_ascii_top test failed");
      end
      $finish;
   end

endmodule

>>> signed_int_to_decimal_ascii_top.f
hdl/sitda_pkg.sv
hdl/sitda_cell.sv
hdl/signed_int_to_decimal_ascii_top.sv
dv/signed_int_to_decimal_ascii_top_tb.sv
